// ===== src/blinds_motor_sequencer_unit_macros.svh =====
// Assertion macros for the blinds motor sequencer.
// Used by blinds_motor_sequencer_unit.sv; expects clk and rst_n in scope.
`ifndef BLINDS_MOTOR_SEQUENCER_UNIT_MACROS_SVH
`define BLINDS_MOTOR_SEQUENCER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bms assertion failed");
// next-cycle implication
`define BMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bms assertion failed");
`else
`define BMS_ASSERT_IMP(lbl, ante, cons)
`define BMS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/bms_pkg.sv =====
// Types and constants for the blinds motor sequencer.
// No dependencies.
package bms_pkg;

  typedef enum logic [3:0] {
    MODE_STOP        = 4'd0,
    MODE_PAUSED      = 4'd1,
    MODE_LAUNCH_DOWN = 4'd2,
    MODE_GOING_DOWN  = 4'd3,
    MODE_FULLY_DOWN  = 4'd4,
    MODE_REV_TO_UP   = 4'd5,
    MODE_LAUNCH_UP   = 4'd6,
    MODE_GOING_UP    = 4'd7,
    MODE_FULLY_UP    = 4'd8,
    MODE_REV_TO_DOWN = 4'd9
  } mode_t;

  // configuration register indexes
  localparam logic CFG_TRAVEL_TIME   = 1'b0;
  localparam logic CFG_REVERSE_DELAY = 1'b1;

  localparam logic [15:0] TRAVEL_TIME_RST   = 16'd30;
  localparam logic [15:0] REVERSE_DELAY_RST = 16'd500;

  // floor(ms / 1000) == (ms * RECIP_1000) >> RECIP_SHIFT for any 32-bit ms
  localparam int          MS_W        = 32;
  localparam int          SEC_W       = 23;  // 2^32 / 1000 fits in 23 bits
  localparam int          PROD_W      = 61;
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;

endpackage

// ===== src/blinds_motor_sequencer_unit.sv =====
// Blinds motor sequencer top level: poll register, sequencer update, result beat.
// Depends on bms_pkg and blinds_motor_sequencer_unit_macros.svh.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  in_     | in  | tvalid/tready      | tdata: up_level, down_level, now_ms
//  out_    | out | tvalid/tready      | tdata: relay_power, relay_direction, mode_code
//  cfg_    | in  | wr_en, no wait     | addr: register index, data: 16-bit value
//
// One beat per cycle sustained while out_tready is high; a result beat is valid once its
// poll has passed the poll register (loaded at the accepting edge) and then the sequencer
// state, which is also the result register.
// The seconds value of now_ms comes from a reciprocal multiply ahead of the poll
// register; the mode, start stamp and relay registers all feed back into the sequencer.
// Synchronous active-low reset: stop mode, relays off, both beat slots empty.
// A stalled result holds the state; one more poll waits in the poll register.
`include "blinds_motor_sequencer_unit_macros.svh"

module blinds_motor_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [0] up_level, [1] down_level, [33:2] now_ms, rest 0
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] relay_power, [1] relay_direction, [5:2] mode_code
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);

  // ---------------------------------------------------------------- config
  logic [15:0] travel_time_r;
  logic [15:0] reverse_delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_time_r   <= bms_pkg::TRAVEL_TIME_RST;
      reverse_delay_r <= bms_pkg::REVERSE_DELAY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        bms_pkg::CFG_TRAVEL_TIME:   travel_time_r   <= cfg_data;
        bms_pkg::CFG_REVERSE_DELAY: reverse_delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic advance;     // poll register moves into the sequencer state
  logic in_fire;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire)      s1_valid_r <= 1'b1;
      else if (advance) s1_valid_r <= 1'b0;
      if (advance)         out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- poll register
  logic [bms_pkg::MS_W-1:0]   in_ms;
  logic [bms_pkg::PROD_W-1:0] sec_prod;
  logic [bms_pkg::SEC_W-1:0]  in_sec;

  assign in_ms    = in_tdata[33:2];
  // seconds = ms / 1000 via reciprocal; exact over the full 32-bit range
  assign sec_prod = bms_pkg::PROD_W'(in_ms) * bms_pkg::PROD_W'(bms_pkg::RECIP_1000);
  assign in_sec   = sec_prod[bms_pkg::RECIP_SHIFT +: bms_pkg::SEC_W];

  logic                       s1_up_r;
  logic                       s1_down_r;
  logic [bms_pkg::MS_W-1:0]   s1_ms_r;
  logic [bms_pkg::SEC_W-1:0]  s1_sec_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_up_r   <= in_tdata[0];
      s1_down_r <= in_tdata[1];
      s1_ms_r   <= in_ms;
      s1_sec_r  <= in_sec;
    end
  end

  // ---------------------------------------------------------------- sequencer
  bms_pkg::mode_t             mode_r, mode_nxt;
  logic                       prev_up_r, prev_down_r;
  logic [bms_pkg::SEC_W-1:0]  travel_start_r, travel_start_nxt;
  logic [bms_pkg::MS_W-1:0]   reverse_start_r, reverse_start_nxt;
  logic                       power_r, power_nxt;
  logic                       dir_r, dir_nxt;

  logic                       up_edge, down_edge;
  logic [bms_pkg::MS_W-1:0]   travel_elapsed;   // seconds, mod 2^32
  logic [bms_pkg::MS_W-1:0]   reverse_elapsed;  // ms, mod 2^32
  logic                       travel_done, reverse_done;

  assign up_edge         = s1_up_r && !prev_up_r;
  assign down_edge       = s1_down_r && !prev_down_r;
  assign travel_elapsed  = bms_pkg::MS_W'(s1_sec_r) - bms_pkg::MS_W'(travel_start_r);
  assign reverse_elapsed = s1_ms_r - reverse_start_r;
  assign travel_done     = travel_elapsed >= bms_pkg::MS_W'(travel_time_r);
  assign reverse_done    = reverse_elapsed >= bms_pkg::MS_W'(reverse_delay_r);

  // later checks override earlier ones, so a timeout wins
  always_comb begin
    mode_nxt          = mode_r;
    travel_start_nxt  = travel_start_r;
    reverse_start_nxt = reverse_start_r;
    power_nxt         = power_r;
    dir_nxt           = dir_r;
    case (mode_r)
      bms_pkg::MODE_STOP: begin
        power_nxt = 1'b0;
        dir_nxt   = 1'b0;
        mode_nxt  = bms_pkg::MODE_PAUSED;
      end
      bms_pkg::MODE_PAUSED: begin
        if (down_edge) mode_nxt = bms_pkg::MODE_LAUNCH_DOWN;
        if (up_edge)   mode_nxt = bms_pkg::MODE_LAUNCH_UP;
      end
      bms_pkg::MODE_LAUNCH_DOWN: begin
        power_nxt        = 1'b1;
        dir_nxt          = 1'b1;
        travel_start_nxt = s1_sec_r;
        mode_nxt         = bms_pkg::MODE_GOING_DOWN;
      end
      bms_pkg::MODE_GOING_DOWN: begin
        if (down_edge) mode_nxt = bms_pkg::MODE_STOP;
        if (up_edge) begin
          power_nxt         = 1'b0;
          dir_nxt           = 1'b0;
          reverse_start_nxt = s1_ms_r;
          mode_nxt          = bms_pkg::MODE_REV_TO_UP;
        end
        if (travel_done) begin
          power_nxt = 1'b0;
          dir_nxt   = 1'b0;
          mode_nxt  = bms_pkg::MODE_FULLY_DOWN;
        end
      end
      bms_pkg::MODE_FULLY_DOWN: begin
        if (up_edge) mode_nxt = bms_pkg::MODE_LAUNCH_UP;
      end
      bms_pkg::MODE_REV_TO_UP: begin
        if (reverse_done) mode_nxt = bms_pkg::MODE_LAUNCH_UP;
      end
      bms_pkg::MODE_LAUNCH_UP: begin
        power_nxt        = 1'b1;
        dir_nxt          = 1'b0;
        travel_start_nxt = s1_sec_r;
        mode_nxt         = bms_pkg::MODE_GOING_UP;
      end
      bms_pkg::MODE_GOING_UP: begin
        // a down press still cuts relays and stamps time even if up wins
        if (down_edge) begin
          power_nxt         = 1'b0;
          dir_nxt           = 1'b0;
          reverse_start_nxt = s1_ms_r;
          mode_nxt          = bms_pkg::MODE_REV_TO_DOWN;
        end
        if (up_edge) mode_nxt = bms_pkg::MODE_STOP;
        if (travel_done) begin
          power_nxt = 1'b0;
          dir_nxt   = 1'b0;
          mode_nxt  = bms_pkg::MODE_FULLY_UP;
        end
      end
      bms_pkg::MODE_FULLY_UP: begin
        if (down_edge) mode_nxt = bms_pkg::MODE_LAUNCH_DOWN;
      end
      bms_pkg::MODE_REV_TO_DOWN: begin
        if (reverse_done) mode_nxt = bms_pkg::MODE_LAUNCH_DOWN;
      end
      default: mode_nxt = bms_pkg::MODE_STOP;  // unused codes, relays untouched
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= bms_pkg::MODE_STOP;
      prev_up_r       <= 1'b0;
      prev_down_r     <= 1'b0;
      travel_start_r  <= '0;
      reverse_start_r <= '0;
      power_r         <= 1'b0;
      dir_r           <= 1'b0;
    end else if (advance) begin
      mode_r          <= mode_nxt;
      prev_up_r       <= s1_up_r;
      prev_down_r     <= s1_down_r;
      travel_start_r  <= travel_start_nxt;
      reverse_start_r <= reverse_start_nxt;
      power_r         <= power_nxt;
      dir_r           <= dir_nxt;
    end
  end

  // sequencer state doubles as the result register
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, mode_r, dir_r, power_r};

  // ---------------------------------------------------------------- checks
  `BMS_ASSERT_NXT(a_state_holds, !advance, $stable(mode_r) && $stable(power_r))
  `BMS_ASSERT_NXT(a_poll_kept, s1_valid_r && !advance, s1_valid_r)
  `BMS_ASSERT_IMP(a_power_modes, power_r,
    mode_r == bms_pkg::MODE_GOING_DOWN || mode_r == bms_pkg::MODE_GOING_UP ||
    mode_r == bms_pkg::MODE_STOP)
  `BMS_ASSERT_IMP(a_down_dir, power_r && mode_r == bms_pkg::MODE_GOING_DOWN, dir_r)

endmodule
